>>> design/websocket_frame_deframer_assert.svh
// Assertion macros used by the deframer parser module.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WSD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

>>> design/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'ha;

	localparam logic [2:0] KIND_BYTE  = 3'd0;
	localparam logic [2:0] KIND_EMPTY = 3'd1;
	localparam logic [2:0] KIND_BIN   = 3'd2;
	localparam logic [2:0] KIND_PING  = 3'd3;
	localparam logic [2:0] KIND_PONG  = 3'd4;
	localparam logic [2:0] KIND_CLOSE = 3'd5;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] opcode;
		logic [7:0] payload_byte;
		logic       last_in_frame;
		logic       final_fragment;
	} res_t;

endpackage

>>> design/websocket_frame_deframer.sv
// A word accepted into the input register is parsed into the result register, which drives result_valid.
// Throughput: one word per cycle while the sink takes results; the combinational parse
//   step between the input register and the result register sets this.
// A word that causes no result (header, mask key, skipped payload) leaves no bubble, but
//   a result held by result_stall holds the next word in the input register.
// Reset: arst_n low clears the input and result valid bits and returns the parser to
//   expect the first header byte of a frame; a closed stream reopens only on reset.
module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] kind,
	output logic [3:0] opcode,
	output logic [7:0] payload_byte,
	output logic       last_in_frame,
	output logic       final_fragment
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       accept;
	logic       step;
	logic       free;
	logic       fire;
	res_t       res;
	res_t       res_q;

	// Parse the held word once the result register has room (empty or draining).
	assign step       = valid_s1 && free;
	// Stall only while the held word cannot move on.
	assign data_stall = valid_s1 && !step;
	assign accept     = data_valid && !data_stall;

	// Input register: take a word whenever the held one advances or none is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_s1 <= data_byte;
	end

	// Header decode, length and key capture, unmasking: one step per word.
	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.fire    (fire),
		.res     (res)
	);

	// Hold the result until the sink takes it.
	wsd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.fire         (fire),
		.res          (res),
		.result_stall (result_stall),
		.free         (free),
		.result_valid (result_valid),
		.res_q        (res_q)
	);

	assign kind           = res_q.kind;
	assign opcode         = res_q.opcode;
	assign payload_byte   = res_q.payload_byte;
	assign last_in_frame  = res_q.last_in_frame;
	assign final_fragment = res_q.final_fragment;

endmodule

>>> design/wsd_parser.sv
// Frame header parser state and one-word parse step.
`include "websocket_frame_deframer_assert.svh"

module wsd_parser
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	output logic       fire,
	output res_t       res
);

	typedef enum logic [2:0] {
		PH_BYTE0,
		PH_BYTE1,
		PH_EXTLEN,
		PH_KEY,
		PH_DATA,
		PH_SKIP,
		PH_CLOSED
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  hl_q, hl_n, hl_dec;
	logic [63:0] pl_q, pl_n, pl_dec;
	logic [3:0]  op_q, op_n;
	logic        fin_q, fin_n;
	logic        masked_q, masked_n;
	logic [31:0] key_q, key_n;
	logic [1:0]  pos_q, pos_n;
	logic        done_len, done_hdr;
	logic [7:0]  key_byte;

	assign hl_dec   = (hl_q != 4'd0) ? hl_q - 4'd1 : hl_q;
	assign pl_dec   = (pl_q != 64'd0) ? pl_q - 64'd1 : pl_q;
	assign key_byte = masked_q ? key_q[{~pos_q, 3'b000} +: 8] : 8'd0;

	always_comb begin
		phase_n  = phase_q;
		hl_n     = hl_q;
		pl_n     = pl_q;
		op_n     = op_q;
		fin_n    = fin_q;
		masked_n = masked_q;
		key_n    = key_q;
		pos_n    = pos_q;
		done_len = 1'b0;
		done_hdr = 1'b0;
		fire     = 1'b0;
		res      = '{kind: KIND_BYTE, opcode: op_q, payload_byte: 8'd0,
			last_in_frame: 1'b1, final_fragment: fin_q};

		case (phase_q)
			PH_BYTE0: begin
				fin_n    = byte_s1[7];
				op_n     = byte_s1[3:0];
				masked_n = 1'b0;
				key_n    = 32'd0;
				pos_n    = 2'd0;
				pl_n     = 64'd0;
				hl_n     = 4'd0;
				phase_n  = PH_BYTE1;
			end
			PH_BYTE1: begin
				masked_n = byte_s1[7];
				if (byte_s1[6:0] == LEN16_CODE || byte_s1[6:0] == LEN64_CODE) begin
					hl_n    = (byte_s1[6:0] == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
					pl_n    = 64'd0;
					phase_n = PH_EXTLEN;
				end else begin
					pl_n     = {57'd0, byte_s1[6:0]};
					done_len = 1'b1;
				end
			end
			PH_EXTLEN: begin
				pl_n = {pl_q[55:0], byte_s1};
				hl_n = hl_dec;
				if (hl_dec == 4'd0)
					done_len = 1'b1;
			end
			PH_KEY: begin
				key_n = {key_q[23:0], byte_s1};
				hl_n  = hl_dec;
				if (hl_dec == 4'd0)
					done_hdr = 1'b1;
			end
			PH_DATA: begin
				pos_n = pos_q + 2'd1;
				pl_n  = pl_dec;
				fire  = 1'b1;
				res.payload_byte  = byte_s1 ^ key_byte;
				res.last_in_frame = (pl_dec == 64'd0);
				if (pl_dec == 64'd0)
					phase_n = PH_BYTE0;
			end
			PH_SKIP: begin
				pl_n = pl_dec;
				if (pl_dec == 64'd0)
					phase_n = PH_BYTE0;
			end
			default: begin
				// closed: drop the word
			end
		endcase

		// length known: fetch the mask key or finish the header
		if (done_len) begin
			if (masked_n) begin
				hl_n    = KEY_BYTES;
				phase_n = PH_KEY;
			end else begin
				done_hdr = 1'b1;
			end
		end

		if (done_hdr) begin
			pos_n = 2'd0;
			case (op_q)
				OP_CONT, OP_TEXT: begin
					if (pl_n == 64'd0) begin
						phase_n  = PH_BYTE0;
						fire     = 1'b1;
						res.kind = KIND_EMPTY;
					end else begin
						phase_n = PH_DATA;
					end
				end
				OP_BINARY, OP_PING, OP_PONG: begin
					phase_n = (pl_n == 64'd0) ? PH_BYTE0 : PH_SKIP;
					fire    = 1'b1;
					res.kind = (op_q == OP_BINARY) ? KIND_BIN :
						(op_q == OP_PING) ? KIND_PING : KIND_PONG;
				end
				default: begin
					phase_n  = PH_CLOSED;
					fire     = 1'b1;
					res.kind = KIND_CLOSE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BYTE0;
			hl_q     <= 4'd0;
			pl_q     <= 64'd0;
			op_q     <= 4'd0;
			fin_q    <= 1'b0;
			masked_q <= 1'b0;
			key_q    <= 32'd0;
			pos_q    <= 2'd0;
		end else if (step) begin
			phase_q  <= phase_n;
			hl_q     <= hl_n;
			pl_q     <= pl_n;
			op_q     <= op_n;
			fin_q    <= fin_n;
			masked_q <= masked_n;
			key_q    <= key_n;
			pos_q    <= pos_n;
		end
	end

	`WSD_ASSERT_NOW(a_extlen_count, phase_q == PH_EXTLEN, hl_q != 4'd0 && hl_q <= EXT64_BYTES)
	`WSD_ASSERT_NOW(a_key_masked, phase_q == PH_KEY, masked_q && hl_q != 4'd0 && hl_q <= KEY_BYTES)
	`WSD_ASSERT_NOW(a_data_left, phase_q == PH_DATA || phase_q == PH_SKIP, pl_q != 64'd0)
	`WSD_ASSERT_NEXT(a_closed_sticks, phase_q == PH_CLOSED, phase_q == PH_CLOSED)
	`WSD_ASSERT_NOW(a_closed_silent, phase_q == PH_CLOSED, !fire)

endmodule

>>> design/wsd_out_reg.sv
// Result register that holds a finished result until the sink takes it.
module wsd_out_reg
	import wsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic fire,
	input  res_t res,
	input  logic result_stall,
	output logic free,
	output logic result_valid,
	output res_t res_q
);

	logic valid_q;

	assign free         = !valid_q || !result_stall;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= fire;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && fire)
			res_q <= res;
	end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the WebSocket frame deframer: framed byte stream in, results checked.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wsd_pkg::*;

	// Run shape: random part length, drain wait after the last result, hard cycle cap.
	localparam int unsigned RANDOM_ITEMS = 1750;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	// Parse phases of the tracking copy of the deframer.
	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_KEY,
		PH_DATA,
		PH_SKIP,
		PH_CLOSED
	} phase_t;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       data_valid     = 1'b0;
	logic       data_stall;
	logic [7:0] data_byte      = 8'h00;
	logic       result_valid;
	logic       result_stall   = 1'b0;
	logic [2:0] kind;
	logic [3:0] opcode;
	logic [7:0] payload_byte;
	logic       last_in_frame;
	logic       final_fragment;

	// Tracking copy of the parser state, advanced once per accepted word.
	phase_t      fr_phase;
	logic [3:0]  fr_hdr_left;
	logic [63:0] fr_remaining;
	logic [3:0]  fr_opcode;
	logic        fr_fin;
	logic        fr_masked;
	logic [31:0] fr_key;
	logic [1:0]  fr_key_idx;

	// Results the deframer owes us, oldest first.
	res_t deframed_q[$];

	int unsigned err_count       = 0;
	int unsigned cycle_count     = 0;
	int unsigned words_sent      = 0;
	int unsigned frames_sent     = 0;
	int unsigned results_checked = 0;
	int unsigned tx_idle_pct     = 0;
	int unsigned rx_idle_pct     = 0;
	int unsigned rx_hold         = 0;
	bit          end_with_close;

	websocket_frame_deframer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_valid     (data_valid),
		.data_stall     (data_stall),
		.data_byte      (data_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.kind           (kind),
		.opcode         (opcode),
		.payload_byte   (payload_byte),
		.last_in_frame  (last_in_frame),
		.final_fragment (final_fragment)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Header is complete: decide whether the frame yields an event now, payload bytes
	// later, or shuts the stream.
	function automatic bit header_done(output res_t r);
		r = '0;
		r.opcode         = fr_opcode;
		r.final_fragment = fr_fin;
		r.last_in_frame  = 1'b1;
		fr_key_idx       = '0;
		case (fr_opcode)
			OP_CONT, OP_TEXT: begin
				if (fr_remaining == 0) begin
					fr_phase = PH_HDR0;
					r.kind   = KIND_EMPTY;
					return 1'b1;
				end
				fr_phase = PH_DATA;
				return 1'b0;
			end
			OP_BINARY, OP_PING, OP_PONG: begin
				if (fr_opcode == OP_BINARY)
					r.kind = KIND_BIN;
				else if (fr_opcode == OP_PING)
					r.kind = KIND_PING;
				else
					r.kind = KIND_PONG;
				// Skip the payload of event frames; an empty one goes straight to the next header.
				fr_phase = (fr_remaining == 0) ? PH_HDR0 : PH_SKIP;
				return 1'b1;
			end
			default: begin
				// Close and every unknown opcode shut the stream for good.
				fr_phase = PH_CLOSED;
				r.kind   = KIND_CLOSE;
				return 1'b1;
			end
		endcase
	endfunction

	// Length is complete: collect the mask key first if the frame is masked.
	function automatic bit length_done(output res_t r);
		r = '0;
		if (fr_masked) begin
			fr_hdr_left = KEY_BYTES;
			fr_phase    = PH_KEY;
			return 1'b0;
		end
		return header_done(r);
	endfunction

	// Advance the tracking parser by one received byte; return 1 when it yields a result.
	function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
		logic [7:0] key_byte;
		r = '0;
		case (fr_phase)
			PH_HDR0: begin
				// RSV bits 6..4 are ignored on purpose.
				fr_fin       = b[7];
				fr_opcode    = b[3:0];
				fr_masked    = 1'b0;
				fr_key       = '0;
				fr_key_idx   = '0;
				fr_remaining = '0;
				fr_hdr_left  = '0;
				fr_phase     = PH_HDR1;
				return 1'b0;
			end
			PH_HDR1: begin
				fr_masked    = b[7];
				fr_remaining = '0;
				if (b[6:0] == LEN16_CODE || b[6:0] == LEN64_CODE) begin
					fr_hdr_left = (b[6:0] == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
					fr_phase    = PH_EXTLEN;
					return 1'b0;
				end
				fr_remaining = {57'd0, b[6:0]};
				return length_done(r);
			end
			PH_EXTLEN: begin
				// Big-endian; a 64-bit length with its top bit set is kept as is.
				fr_remaining = {fr_remaining[55:0], b};
				if (fr_hdr_left != 0)
					fr_hdr_left--;
				if (fr_hdr_left == 0)
					return length_done(r);
				return 1'b0;
			end
			PH_KEY: begin
				fr_key = {fr_key[23:0], b};
				if (fr_hdr_left != 0)
					fr_hdr_left--;
				if (fr_hdr_left == 0)
					return header_done(r);
				return 1'b0;
			end
			PH_DATA: begin
				// First key byte sits in bits 31..24 and unmasks payload byte 0.
				key_byte   = fr_masked ? fr_key[8 * (3 - fr_key_idx) +: 8] : 8'h00;
				fr_key_idx = fr_key_idx + 2'd1;
				if (fr_remaining != 0)
					fr_remaining--;
				r.kind           = KIND_BYTE;
				r.opcode         = fr_opcode;
				r.payload_byte   = b ^ key_byte;
				r.last_in_frame  = (fr_remaining == 0);
				r.final_fragment = fr_fin;
				if (fr_remaining == 0)
					fr_phase = PH_HDR0;
				return 1'b1;
			end
			PH_SKIP: begin
				if (fr_remaining != 0)
					fr_remaining--;
				if (fr_remaining == 0)
					fr_phase = PH_HDR0;
				return 1'b0;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// Send one word: maybe idle for a burst first, then hold valid and payload until accepted.
	// Valid stays high on return so back-to-back words leave no bubble.
	task automatic send_byte(input logic [7:0] b);
		res_t        r;
		int unsigned gap;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 13);
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= b;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		// Word accepted at this edge: advance the tracker and queue what it owes.
		if (deframe_byte(b, r))
			deframed_q.push_back(r);
		words_sent++;
	endtask

	// Build one frame on the wire. form picks the length encoding (0: 7-bit, 1: 16-bit,
	// 2: 64-bit); body is how many payload bytes actually go out, normally equal to len.
	task automatic send_frame(input logic [3:0] op, input logic fin, input logic [2:0] rsv,
			input logic masked, input logic [63:0] len, input int form,
			input int unsigned body);
		logic [31:0] key;
		logic [7:0]  pb;
		int          i;
		int unsigned n;
		send_byte({fin, rsv, op});
		if (form == 1)
			send_byte({masked, LEN16_CODE});
		else if (form == 2)
			send_byte({masked, LEN64_CODE});
		else
			send_byte({masked, len[6:0]});
		if (form == 1) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end else if (form == 2) begin
			for (i = 7; i >= 0; i--)
				send_byte(len[8 * i +: 8]);
		end
		key = $urandom();
		if (masked) begin
			for (i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
		end
		for (n = 0; n < body; n++) begin
			// Mix in the byte extremes now and then.
			case ($urandom_range(0, 15))
				0:       pb = 8'h00;
				1:       pb = 8'hff;
				default: pb = 8'($urandom());
			endcase
			send_byte(pb);
		end
		frames_sent++;
	endtask

	// Compare one field and report any mismatch.
	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endtask

	// Result side: check every accepted result against the oldest owed result, then
	// decide the stall for the next cycle in random bursts.
	always @(posedge clk) begin : result_side
		res_t got;
		res_t want;
		if (result_valid && !result_stall) begin
			got = {kind, opcode, payload_byte, last_in_frame, final_fragment};
			if (deframed_q.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, actual kind %0d op %0d byte %0d",
					$time, got.kind, got.opcode, got.payload_byte);
			end else begin
				want = deframed_q.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("opcode", 32'(want.opcode), 32'(got.opcode));
				check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
				check_field("last_in_frame", 32'(want.last_in_frame),
					32'(got.last_in_frame));
				check_field("final_fragment", 32'(want.final_fragment),
					32'(got.final_fragment));
				results_checked++;
			end
		end
		if (rx_hold > 0) begin
			rx_hold--;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < rx_idle_pct) begin
			rx_hold = $urandom_range(1, 13) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Hard cap on run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Text and continuation frames: extremes passing unmasked, masked empty frame,
	// empty continuation with all RSV bits set, masked bytes through every key position.
	task automatic test_data_frames();
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		send_byte({1'b1, 3'b000, OP_TEXT});
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hff);
		send_frame(OP_TEXT, 1'b1, 3'b000, 1'b1, 64'd0, 0, 0);
		send_byte({1'b0, 3'b111, OP_CONT});
		send_byte(8'h00);
		send_frame(OP_TEXT, 1'b0, 3'b000, 1'b1, 64'd4, 0, 4);
	endtask

	// Event frames: empty ping, masked pong with a payload to skip, empty binary via the
	// 16-bit length, then a continuation after binary via the 64-bit length.
	task automatic test_event_frames();
		send_byte({1'b1, 3'b000, OP_PING});
		send_byte(8'h00);
		send_frame(OP_PONG, 1'b1, 3'b000, 1'b1, 64'd1, 0, 1);
		send_frame(OP_BINARY, 1'b0, 3'b010, 1'b0, 64'd0, 1, 0);
		send_frame(OP_CONT, 1'b1, 3'b101, 1'b0, 64'd1, 2, 1);
	endtask

	// Well-formed frames with random content and encodings; idling changes every few
	// dozen frames and stops near the end.
	task automatic test_random_frames();
		int unsigned items;
		int unsigned sel;
		int          form;
		logic [63:0] len;
		logic [3:0]  op;
		logic        masked;
		items = 0;
		while (items < RANDOM_ITEMS) begin
			if (frames_sent % 32 == 0) begin
				sel = $urandom_range(0, 2);
				tx_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 8 : 30;
				sel = $urandom_range(0, 2);
				rx_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 8 : 30;
			end
			if (items + 200 > RANDOM_ITEMS) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			sel = $urandom_range(0, 99);
			if (sel < 35)
				op = OP_TEXT;
			else if (sel < 60)
				op = OP_CONT;
			else if (sel < 75)
				op = OP_BINARY;
			else if (sel < 88)
				op = OP_PING;
			else
				op = OP_PONG;
			// Mostly short frames; the longer encodings carry small lengths too.
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				form = 0;
				len  = 64'($urandom_range(0, 8));
			end else if (sel < 75) begin
				form = 0;
				len  = 64'($urandom_range(9, 40));
			end else if (sel < 82) begin
				form = 0;
				len  = 64'($urandom_range(100, 125));
			end else if (sel < 94) begin
				form = 1;
				len  = 64'($urandom_range(0, 300));
			end else begin
				form = 2;
				len  = 64'($urandom_range(0, 64));
			end
			masked = 1'($urandom_range(0, 1));
			send_frame(op, 1'($urandom_range(0, 1)), 3'($urandom()), masked, len, form,
				int'(len));
			// Count every word of the frame, skipped payload included.
			items += 2 + ((form == 1) ? 2 : (form == 2) ? 8 : 0) + (masked ? 4 : 0);
			items += int'(len);
		end
	endtask

	// Terminal case, since only reset leaves it: either a close or unknown opcode followed
	// by words that must all be dropped, or a 64-bit length with its top bit set.
	task automatic test_stream_end();
		logic [63:0] len;
		logic [3:0]  op;
		int unsigned i;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		if (end_with_close) begin
			i = $urandom_range(0, 10);
			if (i < 5)
				op = 4'(i + 3);
			else if (i == 5)
				op = OP_CLOSE;
			else
				op = 4'(i + 5);
			len = 64'($urandom_range(0, 10));
			send_frame(op, 1'($urandom_range(0, 1)), 3'($urandom()),
				1'($urandom_range(0, 1)), len, 0, int'(len));
			for (i = 0; i < 24; i++)
				send_byte(8'($urandom()));
		end else begin
			len     = {$urandom(), $urandom()};
			len[63] = 1'b1;
			op      = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
			send_frame(op, 1'($urandom_range(0, 1)), 3'($urandom()),
				1'($urandom_range(0, 1)), len, 2, 48);
		end
		data_valid <= 1'b0;
	endtask

	initial begin
		// Tracker starts where the parser starts after reset.
		fr_phase       = PH_HDR0;
		fr_hdr_left    = '0;
		fr_remaining   = '0;
		fr_opcode      = '0;
		fr_fin         = 1'b0;
		fr_masked      = 1'b0;
		fr_key         = '0;
		fr_key_idx     = '0;
		end_with_close = ($urandom_range(0, 3) != 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_data_frames();
		test_event_frames();
		test_random_frames();
		test_stream_end();

		// Drain: wait for every owed result, then wait out DRAIN_CYCLES to catch strays.
		while (deframed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d frames, %0d words sent, %0d results checked", frames_sent,
			words_sent, results_checked);
		$display("tb_top: stream ended on %s", end_with_close ?
			"a close or unknown opcode" : "a 64-bit length with its top bit set");
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
